[rtl/hdsp_pkg.sv]
// Package with shared constants and types of the hard-disk sequential placement block.
`default_nettype none

package hdsp_pkg;

   // Store depth and the widths that follow from it.
   localparam int MAX_DISKS = 1024;
   localparam int IDX_W     = $clog2(MAX_DISKS);
   localparam int CNT_W     = $clog2(MAX_DISKS + 1);

   // Fixed field widths.
   localparam int COORD_W   = 6;
   localparam int CENTRE_W  = 2 * COORD_W;
   localparam int SQ_W      = 2 * COORD_W;
   localparam int DIST_W    = 13;
   localparam int ATTEMPT_W = 16;
   localparam int PLACED_W  = 11;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;

   // Register reset values.
   localparam logic [ATTEMPT_W-1:0] ATTEMPT_LIMIT_RST = 16'd1000;
   localparam logic [DIST_W-1:0]    OVERLAP_LIMIT_RST = 13'd4;

   // Register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ATTEMPT_LIMIT = 1'b0,
      CSR_OVERLAP_LIMIT = 1'b1
   } csr_idx_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

endpackage : hdsp_pkg

`default_nettype wire

[rtl/hard_disk_sequential_placement.sv]
// Top level of the hard-disk sequential placement block: centre store, scan sequencer, result.
`default_nettype none

// Hard-disk sequential placement. Each word on the request side is one candidate disk centre
// (pos_x, pos_y on a 64 by 64 grid); it is accepted at a clock edge where start is high and
// busy is low. The candidate is compared with every centre stored in the current run, one
// stored centre per cycle through a single shared distance unit (two 6 by 6 squarers, an
// adder and a compare against overlap_limit) fed from a centre memory with one write port and
// one registered read port. For each item the scan reads the memory once per disk placed so
// far in the run (at most 1024), checks the last word read, if any, and then sees its end;
// the decision state follows, and the result word comes out as the block returns to idle.
// Exactly one result word comes back per item. It sits on the rsp_ ports for a single cycle
// while rsp_valid is high; the receiver cannot stall it, so it must take the word in that
// cycle. busy is already low during the result cycle, so the next start may coincide with it.
// When the rejection count reaches attempt_limit the result shows run_done and the final
// placed count, and the run restarts with an empty store. No clearing pass is needed: only
// entries below the placed count are ever checked. Configuration writes (csr_we, csr_addr,
// csr_wdata) take effect at the clock edge and should be made only while the block is idle.

module hard_disk_sequential_placement
   import hdsp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   // Configuration port.
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,

   // Request channel.
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [COORD_W-1:0]    req_pos_x,
   input  wire logic [COORD_W-1:0]    req_pos_y,

   // Result channel.
   output logic                       rsp_valid,
   output logic                       rsp_accepted,
   output logic [PLACED_W-1:0]        rsp_placed_count,
   output logic                       rsp_run_done,
   output logic                       rsp_store_full
);

   // Centre memory: x in the low bits, y in the high bits.
   logic [CENTRE_W-1:0] centre_mem [MAX_DISKS];

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic                 hit_ff, hit_in;
   logic [COORD_W-1:0]   x_ff, x_in;
   logic [COORD_W-1:0]   y_ff, y_in;
   logic [CNT_W-1:0]     disk_count_ff, disk_count_in;
   logic [ATTEMPT_W-1:0] reject_count_ff, reject_count_in;
   logic [ATTEMPT_W-1:0] attempt_limit_ff;
   logic [DIST_W-1:0]    overlap_limit_ff;
   logic [CENTRE_W-1:0]  rd_data_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_accepted_ff, rsp_accepted_in;
   logic [PLACED_W-1:0]  rsp_placed_ff, rsp_placed_in;
   logic                 rsp_done_ff, rsp_done_in;
   logic                 rsp_full_ff, rsp_full_in;

   logic                 mem_we;
   logic [IDX_W-1:0]     rd_addr;
   logic [IDX_W-1:0]     wr_addr;

   // Shared distance unit working on the word read in the previous cycle.
   logic [COORD_W-1:0]   sx, sy, dx, dy;
   logic [SQ_W-1:0]      dx_sq, dy_sq;
   logic [DIST_W-1:0]    dist_sq;
   logic                 overlap;

   assign sx      = rd_data_ff[COORD_W-1:0];
   assign sy      = rd_data_ff[CENTRE_W-1:COORD_W];
   assign dx      = (sx > x_ff) ? (sx - x_ff) : (x_ff - sx);
   assign dy      = (sy > y_ff) ? (sy - y_ff) : (y_ff - sy);
   assign dx_sq   = {{(SQ_W-COORD_W){1'b0}}, dx} * {{(SQ_W-COORD_W){1'b0}}, dx};
   assign dy_sq   = {{(SQ_W-COORD_W){1'b0}}, dy} * {{(SQ_W-COORD_W){1'b0}}, dy};
   assign dist_sq = {{(DIST_W-SQ_W){1'b0}}, dx_sq} + {{(DIST_W-SQ_W){1'b0}}, dy_sq};
   assign overlap = (dist_sq <= overlap_limit_ff);

   assign rd_addr = idx_ff[IDX_W-1:0];
   assign wr_addr = disk_count_ff[IDX_W-1:0];

   // Sequencer: next state, datapath updates and the result word.
   always_comb begin
      logic                 store_full;
      logic                 accept;
      logic [ATTEMPT_W-1:0] rej_next;
      logic [CNT_W-1:0]     cnt_next;
      logic                 done;

      state_in        = state_ff;
      idx_in          = idx_ff;
      pend_in         = 1'b0;
      hit_in          = hit_ff;
      x_in            = x_ff;
      y_in            = y_ff;
      disk_count_in   = disk_count_ff;
      reject_count_in = reject_count_ff;
      mem_we          = 1'b0;
      rsp_valid_in    = 1'b0;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_placed_in   = rsp_placed_ff;
      rsp_done_in     = rsp_done_ff;
      rsp_full_in     = rsp_full_ff;

      store_full = (disk_count_ff == CNT_W'(MAX_DISKS));
      accept     = !hit_ff && !store_full;
      rej_next   = accept ? reject_count_ff : (reject_count_ff + 1'b1);
      cnt_next   = accept ? (disk_count_ff + 1'b1) : disk_count_ff;
      done       = (rej_next >= attempt_limit_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               x_in     = req_pos_x;
               y_in     = req_pos_y;
               idx_in   = '0;
               hit_in   = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Check the word read last cycle, and read the next one if any remain.
            if (pend_ff && overlap) begin
               hit_in = 1'b1;
            end
            if (idx_ff != disk_count_ff) begin
               pend_in = 1'b1;
               idx_in  = idx_ff + 1'b1;
            end else if (!pend_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            mem_we          = accept;
            rsp_valid_in    = 1'b1;
            rsp_accepted_in = accept;
            rsp_placed_in   = PLACED_W'(cnt_next);
            rsp_done_in     = done;
            rsp_full_in     = !hit_ff && store_full;
            if (done) begin
               disk_count_in   = '0;
               reject_count_in = '0;
            end else begin
               disk_count_in   = cnt_next;
               reject_count_in = rej_next;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         pend_ff         <= 1'b0;
         disk_count_ff   <= '0;
         reject_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         pend_ff         <= pend_in;
         disk_count_ff   <= disk_count_in;
         reject_count_ff <= reject_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         attempt_limit_ff <= ATTEMPT_LIMIT_RST;
         overlap_limit_ff <= OVERLAP_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_addr))
            CSR_ATTEMPT_LIMIT: attempt_limit_ff <= csr_wdata[ATTEMPT_W-1:0];
            CSR_OVERLAP_LIMIT: overlap_limit_ff <= csr_wdata[DIST_W-1:0];
            default: ;
         endcase
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      hit_ff          <= hit_in;
      x_ff            <= x_in;
      y_ff            <= y_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_placed_ff   <= rsp_placed_in;
      rsp_done_ff     <= rsp_done_in;
      rsp_full_ff     <= rsp_full_in;
   end

   // Centre memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         centre_mem[wr_addr] <= {y_ff, x_ff};
      end
      rd_data_ff <= centre_mem[rd_addr];
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_placed_count = rsp_placed_ff;
   assign rsp_run_done     = rsp_done_ff;
   assign rsp_store_full   = rsp_full_ff;

endmodule : hard_disk_sequential_placement

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the hard-disk sequential placement block.
`timescale 1ns / 100ps

module tb_top
   import hdsp_pkg::*;
();

   // A pending word for the driver is either a candidate disk centre or a register write.
   typedef enum logic {
      OFFER_DISK,
      OFFER_CSR
   } offer_kind_type;

   typedef struct packed {
      offer_kind_type        kind;
      logic [COORD_W-1:0]    pos_x;
      logic [COORD_W-1:0]    pos_y;
      logic [2:0]            gap;
      csr_idx_type           csr_index;
      logic [CSR_DATA_W-1:0] csr_value;
   } offer_type;

   // One predicted result word.
   typedef struct packed {
      logic                accepted;
      logic [PLACED_W-1:0] placed_count;
      logic                run_done;
      logic                store_full;
   } outcome_type;

   // All block inputs start at known values.
   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_addr  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  start     = 1'b0;
   logic                  busy;
   logic [COORD_W-1:0]    req_pos_x = '0;
   logic [COORD_W-1:0]    req_pos_y = '0;
   logic                  rsp_valid;
   logic                  rsp_accepted;
   logic [PLACED_W-1:0]   rsp_placed_count;
   logic                  rsp_run_done;
   logic                  rsp_store_full;

   // Words waiting to be driven, and result words still owed by the block.
   offer_type   offer_queue[$];
   outcome_type outcome_queue[$];
   int          mismatch_count = 0;

   // Our own copy of the placement state and of the two registers. Reset happens only once,
   // so the declared values are the post-reset state.
   logic [COORD_W-1:0]   store_x [MAX_DISKS];
   logic [COORD_W-1:0]   store_y [MAX_DISKS];
   int unsigned          disks_placed  = 0;
   logic [ATTEMPT_W-1:0] misses        = '0;
   logic [ATTEMPT_W-1:0] attempt_limit = ATTEMPT_LIMIT_RST;
   logic [DIST_W-1:0]    overlap_limit = OVERLAP_LIMIT_RST;

   hard_disk_sequential_placement dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offers one candidate to the current run and returns the result word it should produce.
   // A candidate within overlap_limit (squared distance) of any stored centre is a miss; a
   // clean candidate with the store already full is also a miss, flagged as store_full.
   // Once the misses reach attempt_limit the run closes and the store empties.
   function automatic outcome_type place_candidate(logic [COORD_W-1:0] x,
                                                   logic [COORD_W-1:0] y);
      outcome_type res;
      logic        hit;
      int          dx;
      int          dy;
      int unsigned i;
      res = '0;
      hit = 1'b0;
      for (i = 0; i < disks_placed; i++) begin
         dx = int'(store_x[i]) - int'(x);
         dy = int'(store_y[i]) - int'(y);
         if (dx * dx + dy * dy <= int'(overlap_limit))
            hit = 1'b1;
      end
      if (hit) begin
         misses = misses + 1'b1;
      end else if (disks_placed >= MAX_DISKS) begin
         res.store_full = 1'b1;
         misses = misses + 1'b1;
      end else begin
         store_x[disks_placed] = x;
         store_y[disks_placed] = y;
         disks_placed++;
         res.accepted = 1'b1;
      end
      res.placed_count = PLACED_W'(disks_placed);
      // The limit is tested after every word, so a zero limit closes the run every time.
      if (misses >= attempt_limit) begin
         res.run_done = 1'b1;
         disks_placed = 0;
         misses = '0;
      end
      return res;
   endfunction

   function automatic void queue_disk(int x, int y, logic calm);
      offer_type o;
      o = '0;
      o.kind = OFFER_DISK;
      o.pos_x = COORD_W'(x);
      o.pos_y = COORD_W'(y);
      o.gap = calm ? 3'd0 : 3'($urandom_range(0, 6));
      offer_queue.push_back(o);
   endfunction

   function automatic void queue_write(csr_idx_type idx, logic [CSR_DATA_W-1:0] value);
      offer_type o;
      o = '0;
      o.kind = OFFER_CSR;
      o.csr_index = idx;
      o.csr_value = value;
      offer_queue.push_back(o);
   endfunction

   task automatic check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // Driver. Each signal gets its next value worked out in a local variable and receives a
   // single nonblocking assignment per edge, so a start that stays high for back-to-back
   // words is never lowered and raised in the same step. A candidate word is predicted at the
   // edge where the block takes it (start high, busy low). A register write waits until no
   // result word is owed and none is on the bus, which means the block is idle, and the
   // register copy used for prediction changes at that same point.
   always @(posedge clock) begin : drive
      logic      start_n;
      logic      we_n;
      offer_type head;
      start_n = start;
      we_n = 1'b0;
      if (reset) begin
         start_n = 1'b0;
      end else begin
         if (start && !busy) begin
            outcome_queue.push_back(place_candidate(req_pos_x, req_pos_y));
            start_n = 1'b0;
         end
         if (!start_n && offer_queue.size() > 0) begin
            head = offer_queue[0];
            if (head.kind == OFFER_CSR) begin
               if (outcome_queue.size() == 0 && !rsp_valid) begin
                  we_n = 1'b1;
                  csr_addr <= head.csr_index;
                  csr_wdata <= head.csr_value;
                  case (head.csr_index)
                     CSR_ATTEMPT_LIMIT: attempt_limit = head.csr_value;
                     CSR_OVERLAP_LIMIT: overlap_limit = head.csr_value[DIST_W-1:0];
                     default: ;
                  endcase
                  void'(offer_queue.pop_front());
               end
            end else if (head.gap != 3'd0) begin
               // The sender idles; the count runs while the block may still be busy, so
               // start rises at varied points of the block's work.
               head.gap = head.gap - 3'd1;
               offer_queue[0] = head;
            end else begin
               start_n = 1'b1;
               req_pos_x <= head.pos_x;
               req_pos_y <= head.pos_y;
               void'(offer_queue.pop_front());
            end
         end
      end
      start <= start_n;
      csr_we <= we_n;
   end

   // Monitor. A result word is valid for exactly one cycle and is taken at the edge that ends
   // it; it is matched against the oldest prediction.
   always @(posedge clock) begin : watch
      outcome_type want;
      if (!reset && rsp_valid) begin
         if (outcome_queue.size() == 0) begin
            $display("%0t: extra word: expected none, actual %0b/%0d/%0b/%0b", $time,
                     rsp_accepted, rsp_placed_count, rsp_run_done, rsp_store_full);
            mismatch_count++;
         end else begin
            want = outcome_queue.pop_front();
            check_field("accepted", want.accepted, rsp_accepted);
            check_field("placed_count", want.placed_count, rsp_placed_count);
            check_field("run_done", want.run_done, rsp_run_done);
            check_field("store_full", want.store_full, rsp_store_full);
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int unsigned          random_items;
      int unsigned          phase_len;
      int unsigned          base;
      int unsigned          stride;
      int unsigned          grid_pt;
      int unsigned          reach;
      int                   i;
      int                   pick;
      int                   x;
      int                   y;
      logic                 calm;
      logic [11:0]          prior;
      logic [11:0]          history[$];
      logic [ATTEMPT_W-1:0] limit_word;

      random_items = 0;

      // Directed part, reset register values first: the grid corners, a neighbor inside the
      // overlap distance, one exactly at it, and one just beyond it.
      queue_disk(0, 0, 1'b0);
      queue_disk(63, 63, 1'b0);
      queue_disk(0, 63, 1'b0);
      queue_disk(63, 0, 1'b0);
      queue_disk(1, 1, 1'b0);
      queue_disk(2, 0, 1'b0);
      queue_disk(3, 0, 1'b0);
      queue_disk(32, 32, 1'b0);
      queue_disk(34, 32, 1'b0);

      // With a zero overlap limit only an identical centre overlaps; the first miss ends the run,
      // as earlier misses already pass the new limit, and the next candidate lands in an empty store.
      queue_write(CSR_OVERLAP_LIMIT, 16'd0);
      queue_write(CSR_ATTEMPT_LIMIT, 16'd2);
      queue_disk(63, 63, 1'b0);
      queue_disk(62, 63, 1'b0);
      queue_disk(0, 0, 1'b0);
      queue_disk(0, 0, 1'b0);

      // A zero attempt limit ends a run on every word, even one that was placed.
      queue_write(CSR_ATTEMPT_LIMIT, 16'd0);
      queue_disk(10, 10, 1'b0);
      queue_disk(10, 10, 1'b0);

      // The widest overlap limit, with junk above the register's width, makes every disk
      // after the first overlap; the widest attempt limit keeps the run open.
      queue_write(CSR_OVERLAP_LIMIT, 16'hFFFF);
      queue_write(CSR_ATTEMPT_LIMIT, 16'hFFFF);
      queue_disk(5, 5, 1'b0);
      queue_disk(60, 60, 1'b0);
      queue_disk(0, 63, 1'b0);

      // Random part in phases, each with its own register setting. Most candidates are
      // uniform, the rest land on or next to a recent one so that misses pile up and runs
      // close. Some phases send words back to back with no idle cycles.
      while (random_items < 580) begin
         case ($urandom_range(0, 9))
            0:       limit_word = 16'd0;
            1:       limit_word = 16'hFFFF;
            2:       limit_word = 16'($urandom);
            default: limit_word = 16'($urandom_range(1, 30));
         endcase
         queue_write(CSR_ATTEMPT_LIMIT, limit_word);
         case ($urandom_range(0, 9))
            0:       reach = 0;
            1:       reach = 8191;
            2:       reach = $urandom_range(0, 8191);
            default: reach = $urandom_range(1, 200);
         endcase
         queue_write(CSR_OVERLAP_LIMIT, {3'($urandom), DIST_W'(reach)});
         calm = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(30, 80);
         repeat (phase_len) begin
            pick = $urandom_range(0, 9);
            if (pick < 6 || history.size() == 0) begin
               x = $urandom_range(0, 63);
               y = $urandom_range(0, 63);
            end else begin
               prior = history[$urandom_range(0, history.size() - 1)];
               x = prior[5:0];
               y = prior[11:6];
               if (pick < 9) begin
                  x = x + int'($urandom_range(0, 6)) - 3;
                  y = y + int'($urandom_range(0, 6)) - 3;
                  if (x < 0) x = 0;
                  if (x > 63) x = 63;
                  if (y < 0) y = 0;
                  if (y > 63) y = 63;
               end
            end
            queue_disk(x, y, calm);
            history.push_back({6'(y), 6'(x)});
            if (history.size() > 64)
               void'(history.pop_front());
            random_items++;
         end
      end

      // Fill the store. A zero limit first closes whatever run is open, then distinct centres
      // with a zero overlap limit are all placed. An odd stride over the 4096 grid points never
      // repeats a point, so the candidates past the store's depth fit but find no room.
      queue_write(CSR_ATTEMPT_LIMIT, 16'd0);
      queue_disk(0, 0, 1'b0);
      queue_write(CSR_ATTEMPT_LIMIT, 16'hFFFF);
      queue_write(CSR_OVERLAP_LIMIT, 16'd0);
      base = $urandom_range(0, 4095);
      stride = 2 * $urandom_range(0, 2047) + 1;
      for (i = 0; i < MAX_DISKS + 3; i++) begin
         grid_pt = (base + i * stride) % 4096;
         queue_disk(grid_pt % 64, grid_pt / 64, 1'b0);
      end
      // On a full store an overlapping candidate is an ordinary miss, not flagged.
      queue_disk(base % 64, base / 64, 1'b0);
      // A lowered limit closes the full run on its next miss and reports the full count.
      queue_write(CSR_ATTEMPT_LIMIT, 16'd5);
      grid_pt = (base + (MAX_DISKS + 3) * stride) % 4096;
      queue_disk(grid_pt % 64, grid_pt / 64, 1'b0);
      queue_disk(63, 63, 1'b0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (offer_queue.size() != 0 || start || outcome_queue.size() != 0)
         @(negedge clock);
      // A word may still be in flight beyond the last prediction; give the longest scan time.
      repeat (1100) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

   // Guard against a hang: several times the slowest legal run.
   initial begin
      #100_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule : tb_top

[files.f]
rtl/hdsp_pkg.sv
rtl/hard_disk_sequential_placement.sv
tb/tb_top.sv
